/* rtl/core/itms_pkg.sv */
// Shared constants for the interlacing triangle Metropolis step core.
package itms_pkg;

  localparam int MAX_COLORS = 16;
  localparam int FRACTION_BITS = 24;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int WEIGHT_W = 32;
  localparam int UNIFORM_BITS = 24;
  localparam int NCOL_W = 5;
  localparam int MOVE_W = 6;
  localparam int PSI_OUT_W = 9;

  localparam logic [1:0] REG_N_COLORS = 2'd0;
  localparam logic [1:0] REG_WEIGHT_Q = 2'd1;
  localparam logic [1:0] REG_WEIGHT_Q_INV = 2'd2;

  localparam logic [NCOL_W-1:0] N_COLORS_RESET = 5'd4;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 32'h0100_0000;

endpackage

/* rtl/core/interlacing_triangle_metropolis_step_core.sv */
// Top level: Metropolis step on a depth-2 colored interlacing triangle.
// Usage:
//   Pulse start with in_restart, in_move_index and in_uniform_fraction while
//   busy is low; that edge is the transfer of one item. busy then stays high
//   until the single result comes out on out_strobe for one cycle with
//   out_valid_move, out_accepted and out_psi_value.
//   A restart gives its result in the cycle after the transfer and never raises
//   busy; an out-of-range or equal-color move ends in S_PROP. A move passes
//   through S_PROP, the level-two reconciliation walk (up to 2n entries, one
//   per cycle), the interlacing scan (one position per color per cycle), the
//   psi scan over n positions, S_PREP and up to |delta| passes through the
//   one Q-format multiplier.
//   The receiver cannot stall: each result is shown for exactly one cycle.
//   Registers over APB (n_colors at 0x0, weight_q at 0x4, weight_q_inverse
//   at 0x8) must be written only while idle, which the block does not
//   enforce; writing n_colors reloads the identity triangle.
//   Reset (synchronous, rst_n low) loads the identity triangle, psi zero,
//   n_colors 4 and both weights 1.0.
module interlacing_triangle_metropolis_step_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_restart,
  input  logic [itms_pkg::MOVE_W-1:0]        in_move_index,
  input  logic [itms_pkg::UNIFORM_BITS-1:0]  in_uniform_fraction,
  output logic                               out_strobe,
  output logic                               out_valid_move,
  output logic                               out_accepted,
  output logic [itms_pkg::PSI_OUT_W-1:0]     out_psi_value,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [itms_pkg::CFG_AW-1:0]        paddr,
  input  logic [itms_pkg::CFG_DW-1:0]        pwdata,
  output logic [itms_pkg::CFG_DW-1:0]        prdata,
  output logic                               pready
);
  import itms_pkg::*;

  localparam int CW = $clog2(MAX_COLORS + 1);
  localparam int PW1 = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int PW2 = PW1 + 1;
  localparam int AW = (CW + 2 > 7) ? CW + 2 : 7;
  localparam int PSW = $clog2(MAX_COLORS * MAX_COLORS + 1);
  localparam int PWW = FRACTION_BITS + 1;
  localparam int MW = PWW + WEIGHT_W;
  localparam int CMPW = UNIFORM_BITS + FRACTION_BITS + 1;
  localparam int L2N = 2 * MAX_COLORS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PROP = 4'd1;
  localparam logic [3:0] S_WALK = 4'd2;
  localparam logic [3:0] S_FIND_DN = 4'd3;
  localparam logic [3:0] S_FIND_UP = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_PSI = 4'd6;
  localparam logic [3:0] S_PREP = 4'd7;
  localparam logic [3:0] S_POW = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [NCOL_W-1:0] ncfg_r, ncfg_nxt;
  logic [WEIGHT_W-1:0] wq_r, wq_nxt, wqi_r, wqi_nxt;
  logic [CW-1:0] l1_r [MAX_COLORS], l1_nxt [MAX_COLORS];
  logic [CW-1:0] l2_r [L2N], l2_nxt [L2N];
  logic [CW-1:0] p1_r [MAX_COLORS], p1_nxt [MAX_COLORS];
  logic [CW-1:0] p2_r [L2N], p2_nxt [L2N];
  logic [CW-1:0] id1 [MAX_COLORS];
  logic [CW-1:0] id2 [L2N];
  logic [PSW-1:0] psi_r, psi_nxt, prop_r, prop_nxt, reps_r, reps_nxt;
  logic [MOVE_W-1:0] m_r, m_nxt;
  logic [UNIFORM_BITS-1:0] u_r, u_nxt;
  logic [AW-1:0] wk_r, wk_nxt, up_r, up_nxt, al_r, al_nxt;
  logic dir_up_r, dir_up_nxt;
  logic [CW-1:0] from_r, from_nxt, to_r, to_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cc_r, cc_nxt;
  logic [PW1-1:0] ci_r, ci_nxt;
  logic [1:0] seen_r, seen_nxt;
  logic [MAX_COLORS:0] live_r, live_nxt;
  logic [WEIGHT_W-1:0] base_r, base_nxt;
  logic [PWW-1:0] pwr_r, pwr_nxt;
  logic out_strobe_r, out_strobe_nxt, out_valid_r, out_valid_nxt, out_acc_r, out_acc_nxt;
  logic [PSI_OUT_W-1:0] out_psi_r, out_psi_nxt;

  logic [CW-1:0] nact;
  logic [AW-1:0] n_a, m_a, pos2_a;
  logic [PW1-1:0] pos1;
  logic [PW2-1:0] q2;
  logic [CW-1:0] va, vb, vl, vr, v0, v1, v2, c0, c1, bb;
  logic [1:0] na, nb, sn;
  logic fail, fin;
  logic [CW-1:0] cnt;
  logic [MAX_COLORS:0] live1;
  logic [MW-1:0] prod, prod_sh;
  logic [PWW-1:0] one;
  logic [CMPW-1:0] lhs, rhs;
  logic wr;
  logic [31:0] psi_ext;

  always_comb begin
    for (int i = 0; i < MAX_COLORS; i++) begin
      id1[i] = CW'(i + 1);
      id2[2 * i] = CW'(i + 1);
      id2[2 * i + 1] = CW'(i + 1);
    end
  end

  always_comb begin
    if (ncfg_r == '0) begin
      nact = CW'(1);
    end else if (32'(ncfg_r) > MAX_COLORS) begin
      nact = CW'(MAX_COLORS);
    end else begin
      nact = CW'(ncfg_r);
    end
  end

  assign n_a = AW'(nact);
  assign m_a = AW'(m_r);
  assign pos2_a = m_a - (n_a - AW'(1));
  assign pos1 = m_a[PW1-1:0];
  assign q2 = pos2_a[PW2-1:0];
  assign one = PWW'(1) << FRACTION_BITS;
  assign wr = psel & penable & pwrite;

  always_comb begin
    state_nxt = state_r;
    ncfg_nxt = ncfg_r;
    wq_nxt = wq_r;
    wqi_nxt = wqi_r;
    l1_nxt = l1_r;
    l2_nxt = l2_r;
    p1_nxt = p1_r;
    p2_nxt = p2_r;
    psi_nxt = psi_r;
    prop_nxt = prop_r;
    reps_nxt = reps_r;
    m_nxt = m_r;
    u_nxt = u_r;
    wk_nxt = wk_r;
    up_nxt = up_r;
    al_nxt = al_r;
    dir_up_nxt = dir_up_r;
    from_nxt = from_r;
    to_nxt = to_r;
    cnt_nxt = cnt_r;
    cc_nxt = cc_r;
    ci_nxt = ci_r;
    seen_nxt = seen_r;
    live_nxt = live_r;
    base_nxt = base_r;
    pwr_nxt = pwr_r;
    out_strobe_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    out_acc_nxt = out_acc_r;
    fin = 1'b0;
    va = '0; vb = '0; vl = '0; vr = '0;
    v0 = '0; v1 = '0; v2 = '0; c0 = '0; c1 = '0; bb = '0;
    na = '0; nb = '0; sn = '0;
    fail = 1'b0;
    cnt = '0;
    live1 = live_r;
    prod = '0;
    prod_sh = '0;
    lhs = '0;
    rhs = '0;

    if (wr) begin
      unique case (paddr[3:2])
        REG_N_COLORS: begin
          ncfg_nxt = pwdata[NCOL_W-1:0];
          l1_nxt = id1;
          l2_nxt = id2;
          psi_nxt = '0;
        end
        REG_WEIGHT_Q: wq_nxt = pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_Q_INV: wqi_nxt = pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_restart) begin
            l1_nxt = id1;
            l2_nxt = id2;
            psi_nxt = '0;
            out_valid_nxt = 1'b0;
            out_acc_nxt = 1'b0;
            fin = 1'b1;
          end else begin
            m_nxt = in_move_index;
            u_nxt = in_uniform_fraction;
            p1_nxt = l1_r;
            p2_nxt = l2_r;
            state_nxt = S_PROP;
          end
        end
      end
      S_PROP: begin
        out_valid_nxt = 1'b0;
        out_acc_nxt = 1'b0;
        state_nxt = S_CHECK;
        cc_nxt = CW'(1);
        ci_nxt = '0;
        seen_nxt = '0;
        if (m_a < n_a - AW'(1)) begin
          va = p1_r[pos1];
          vb = p1_r[pos1 + PW1'(1)];
          vl = p2_r[{pos1, 1'b0}];
          vr = p2_r[{pos1, 1'b1}];
          na = 2'(vl == va) + 2'(vr == va);
          nb = 2'(vl == vb) + 2'(vr == vb);
          up_nxt = {m_a[AW-2:0], 1'b0} + AW'(2);
          from_nxt = va;
          to_nxt = vb;
          if (va == vb) begin
            fin = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            p1_nxt[pos1] = vb;
            p1_nxt[pos1 + PW1'(1)] = va;
            if (na != 2'd0 && nb == 2'd0) begin
              if (vl == va) p2_nxt[{pos1, 1'b0}] = vb;
              if (vr == va) p2_nxt[{pos1, 1'b1}] = vb;
              from_nxt = vb;
              to_nxt = va;
              cnt_nxt = na;
              dir_up_nxt = 1'b1;
              wk_nxt = {m_a[AW-2:0], 1'b0} + AW'(2);
              if (({m_a[AW-2:0], 1'b0} + AW'(2)) < {n_a[AW-2:0], 1'b0}) begin
                state_nxt = S_WALK;
              end
            end else if (na == 2'd0 && nb != 2'd0) begin
              if (vl == vb) p2_nxt[{pos1, 1'b0}] = va;
              if (vr == vb) p2_nxt[{pos1, 1'b1}] = va;
              from_nxt = va;
              to_nxt = vb;
              cnt_nxt = nb;
              dir_up_nxt = 1'b0;
              wk_nxt = {m_a[AW-2:0], 1'b0} - AW'(1);
              if (m_a != '0) state_nxt = S_WALK;
            end else if (na != 2'd0 && nb != 2'd0) begin
              wk_nxt = {m_a[AW-2:0], 1'b0} - AW'(1);
              if (m_a != '0) state_nxt = S_FIND_DN;
            end
          end
        end else if (pos2_a >= {n_a[AW-2:0], 1'b0} - AW'(1)) begin
          fin = 1'b1;
          state_nxt = S_IDLE;
        end else if (p2_r[q2] == p2_r[q2 + PW2'(1)]) begin
          fin = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          p2_nxt[q2] = p2_r[q2 + PW2'(1)];
          p2_nxt[q2 + PW2'(1)] = p2_r[q2];
        end
      end
      S_WALK: begin
        if (p2_r[wk_r[PW2-1:0]] == from_r) begin
          p2_nxt[wk_r[PW2-1:0]] = to_r;
          cnt_nxt = cnt_r - 2'd1;
        end
        if (dir_up_r) wk_nxt = wk_r + AW'(1);
        else wk_nxt = wk_r - AW'(1);
        if (cnt_nxt == 2'd0 ||
            (dir_up_r && wk_r == {n_a[AW-2:0], 1'b0} - AW'(1)) ||
            (!dir_up_r && wk_r == '0)) begin
          state_nxt = S_CHECK;
        end
      end
      S_FIND_DN: begin
        if (p2_r[wk_r[PW2-1:0]] == from_r) begin
          al_nxt = wk_r;
          wk_nxt = up_r;
          if (up_r < {n_a[AW-2:0], 1'b0}) state_nxt = S_FIND_UP;
          else state_nxt = S_CHECK;
        end else if (wk_r == '0) begin
          state_nxt = S_CHECK;
        end else begin
          wk_nxt = wk_r - AW'(1);
        end
      end
      S_FIND_UP: begin
        if (p2_r[wk_r[PW2-1:0]] == to_r) begin
          p2_nxt[al_r[PW2-1:0]] = to_r;
          p2_nxt[wk_r[PW2-1:0]] = from_r;
          state_nxt = S_CHECK;
        end else if (wk_r == {n_a[AW-2:0], 1'b0} - AW'(1)) begin
          state_nxt = S_CHECK;
        end else begin
          wk_nxt = wk_r + AW'(1);
        end
      end
      S_CHECK: begin
        v0 = p2_r[{ci_r, 1'b0}];
        v1 = p1_r[ci_r];
        v2 = p2_r[{ci_r, 1'b1}];
        sn = seen_r;
        if (v0 == cc_r) begin
          if (sn == 2'd3 || sn == 2'd1) fail = 1'b1;
          sn = sn + 2'd1;
        end
        if (v1 == cc_r) begin
          if (sn != 2'd1) fail = 1'b1;
          sn = sn + 2'd1;
        end
        if (v2 == cc_r) begin
          if (sn == 2'd3 || sn == 2'd1) fail = 1'b1;
          sn = sn + 2'd1;
        end
        seen_nxt = sn;
        ci_nxt = ci_r + PW1'(1);
        if (AW'(ci_r) == n_a - AW'(1)) begin
          if (sn != 2'd3) fail = 1'b1;
          ci_nxt = '0;
          seen_nxt = '0;
          cc_nxt = cc_r + CW'(1);
        end
        if (fail) begin
          fin = 1'b1;
          state_nxt = S_IDLE;
        end else if (AW'(ci_r) == n_a - AW'(1) && cc_r == nact) begin
          state_nxt = S_PSI;
          ci_nxt = PW1'(nact - CW'(1));
          live_nxt = '1;
          prop_nxt = '0;
        end
      end
      S_PSI: begin
        c1 = p2_r[{ci_r, 1'b1}];
        bb = p1_r[ci_r];
        c0 = p2_r[{ci_r, 1'b0}];
        live1 = live_r;
        if (32'(c1) <= MAX_COLORS) live1[c1] = 1'b0;
        for (int k = 1; k <= MAX_COLORS; k++) begin
          if (k > 32'(bb) && k <= 32'(nact) && live1[k]) cnt = cnt + CW'(1);
        end
        prop_nxt = prop_r + PSW'(cnt);
        live_nxt = live1;
        if (32'(bb) <= MAX_COLORS) live_nxt[bb] = 1'b1;
        if (32'(c0) <= MAX_COLORS) live_nxt[c0] = 1'b0;
        ci_nxt = ci_r - PW1'(1);
        if (ci_r == '0) state_nxt = S_PREP;
      end
      S_PREP: begin
        pwr_nxt = one;
        if (prop_r >= psi_r) begin
          base_nxt = wq_r;
          reps_nxt = prop_r - psi_r;
        end else begin
          base_nxt = wqi_r;
          reps_nxt = psi_r - prop_r;
        end
        state_nxt = S_POW;
      end
      S_POW: begin
        if (reps_r == '0 || pwr_r == '0) begin
          lhs = CMPW'(u_r) << FRACTION_BITS;
          rhs = CMPW'(pwr_r) << UNIFORM_BITS;
          out_valid_nxt = 1'b1;
          out_acc_nxt = lhs < rhs;
          if (lhs < rhs) begin
            l1_nxt = p1_r;
            l2_nxt = p2_r;
            psi_nxt = prop_r;
          end
          fin = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          prod = MW'(pwr_r) * MW'(base_r);
          prod_sh = prod >> FRACTION_BITS;
          if (prod_sh > MW'(one)) pwr_nxt = one;
          else pwr_nxt = prod_sh[PWW-1:0];
          reps_nxt = reps_r - PSW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    psi_ext = 32'(psi_nxt);
    out_strobe_nxt = fin;
    if (psi_ext > 32'd511) out_psi_nxt = 9'h1FF;
    else out_psi_nxt = psi_ext[PSI_OUT_W-1:0];
    if (!fin) out_psi_nxt = out_psi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ncfg_r <= N_COLORS_RESET;
      wq_r <= WEIGHT_RESET;
      wqi_r <= WEIGHT_RESET;
      l1_r <= id1;
      l2_r <= id2;
      psi_r <= '0;
      out_strobe_r <= 1'b0;
      out_valid_r <= 1'b0;
      out_acc_r <= 1'b0;
      out_psi_r <= '0;
    end else begin
      state_r <= state_nxt;
      ncfg_r <= ncfg_nxt;
      wq_r <= wq_nxt;
      wqi_r <= wqi_nxt;
      l1_r <= l1_nxt;
      l2_r <= l2_nxt;
      psi_r <= psi_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_valid_r <= out_valid_nxt;
      out_acc_r <= out_acc_nxt;
      out_psi_r <= out_psi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
    prop_r <= prop_nxt;
    reps_r <= reps_nxt;
    m_r <= m_nxt;
    u_r <= u_nxt;
    wk_r <= wk_nxt;
    up_r <= up_nxt;
    al_r <= al_nxt;
    dir_up_r <= dir_up_nxt;
    from_r <= from_nxt;
    to_r <= to_nxt;
    cnt_r <= cnt_nxt;
    cc_r <= cc_nxt;
    ci_r <= ci_nxt;
    seen_r <= seen_nxt;
    live_r <= live_nxt;
    base_r <= base_nxt;
    pwr_r <= pwr_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_valid_move = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_psi_value = out_psi_r;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_N_COLORS: prdata = CFG_DW'(ncfg_r);
      REG_WEIGHT_Q: prdata = wq_r;
      REG_WEIGHT_Q_INV: prdata = wqi_r;
      default: prdata = '0;
    endcase
  end

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) != S_IDLE || $past(start)))
    else $error("result transfer without an accepted item");

  a_acc_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_acc_r) |-> out_valid_r)
    else $error("accepted move that was not valid");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_restart) |=> busy)
    else $error("move transfer did not raise busy");

  a_psi_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(psi_r) <= (MAX_COLORS * (MAX_COLORS - 1)) / 2)
    else $error("psi beyond its bound");

  a_pwr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POW) |-> (pwr_r <= one))
    else $error("acceptance power above one");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the interlacing triangle Metropolis step core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import itms_pkg::*;

  localparam int MAXC = 16;
  localparam int FB = 24;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic       valid_move;
    logic       accepted;
    logic [8:0] psi;
  } step_result_t;

  logic clk = 0, rst_n = 0, start = 0;
  logic busy;
  logic in_restart = 0;
  logic [MOVE_W-1:0] in_move_index = '0;
  logic [UNIFORM_BITS-1:0] in_uniform_fraction = '0;
  logic out_strobe, out_valid_move, out_accepted;
  logic [PSI_OUT_W-1:0] out_psi_value;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  interlacing_triangle_metropolis_step_core DUT (.*);

  initial forever #4 clk = ~clk;

  // predictor state
  logic [4:0] ncol_reg;
  logic [31:0] q_reg, qinv_reg;
  logic [4:0] row1 [MAXC];
  logic [4:0] row2 [2*MAXC];
  int psi_now;
  step_result_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;

  function automatic int ncol_eff();
    int n = ncol_reg;
    if (n < 1) n = 1;
    if (n > MAXC) n = MAXC;
    return n;
  endfunction

  function automatic bit is_interlaced(logic [4:0] a [MAXC], logic [4:0] b [2*MAXC], int n);
    int seen;
    int v [3];
    int lv [3];
    int pat [3];
    pat = '{2, 1, 2};
    for (int c = 1; c <= n; c++) begin
      seen = 0;
      for (int i = 0; i < n; i++) begin
        v = '{b[2*i], a[i], b[2*i+1]};
        lv = '{2, 1, 2};
        for (int k = 0; k < 3; k++) begin
          if (v[k] != c) continue;
          if (seen >= 3 || pat[seen] != lv[k]) return 0;
          seen++;
        end
      end
      if (seen != 3) return 0;
    end
    return 1;
  endfunction

  function automatic int psi_stat(logic [4:0] a [MAXC], logic [4:0] b [2*MAXC], int n);
    bit live [MAXC+1];
    int tot = 0;
    int c;
    for (int k = 0; k <= MAXC; k++) live[k] = 1;
    for (int i = n - 1; i >= 0; i--) begin
      c = b[2*i+1];
      if (c <= MAXC) live[c] = 0;
      for (int k = a[i] + 1; k <= n; k++) tot += live[k];
      if (a[i] <= MAXC) live[a[i]] = 1;
      c = b[2*i];
      if (c <= MAXC) live[c] = 0;
    end
    return tot;
  endfunction

  function automatic void reload_identity();
    for (int i = 0; i < MAXC; i++) begin
      row1[i] = 5'(i + 1);
      row2[2*i] = 5'(i + 1);
      row2[2*i+1] = 5'(i + 1);
    end
    psi_now = psi_stat(row1, row2, ncol_eff());
  endfunction

  function automatic step_result_t predict_step(bit rs, int m, logic [23:0] u);
    step_result_t r;
    int n = ncol_eff();
    logic [4:0] p1 [MAXC];
    logic [4:0] p2 [2*MAXC];
    logic [4:0] a, b, t, lft, rgt;
    int na, nb, done, al, br, pos, prop, delta, reps;
    bit ok = 0, acc = 0;
    logic [63:0] pw, base, one;
    if (rs) reload_identity();
    else begin
      p1 = row1;
      p2 = row2;
      if (m < n - 1) begin
        pos = m;
        a = p1[pos];
        b = p1[pos+1];
        if (a != b) begin
          p1[pos] = b;
          p1[pos+1] = a;
          lft = p2[2*pos];
          rgt = p2[2*pos+1];
          na = (lft == a) + (rgt == a);
          nb = (lft == b) + (rgt == b);
          done = 0;
          if (na > 0 && nb == 0) begin
            if (lft == a) p2[2*pos] = b;
            if (rgt == a) p2[2*pos+1] = b;
            for (int i = 2*(pos+1); i < 2*n && done < na; i++)
              if (p2[i] == b) begin p2[i] = a; done++; end
          end else if (na == 0 && nb > 0) begin
            if (lft == b) p2[2*pos] = a;
            if (rgt == b) p2[2*pos+1] = a;
            for (int i = 2*pos - 1; i >= 0 && done < nb; i--)
              if (p2[i] == a) begin p2[i] = b; done++; end
          end else if (na > 0 && nb > 0) begin
            al = -1;
            br = -1;
            for (int i = 2*pos - 1; i >= 0; i--)
              if (p2[i] == a) begin al = i; break; end
            for (int i = 2*(pos+1); i < 2*n; i++)
              if (p2[i] == b) begin br = i; break; end
            if (al >= 0 && br >= 0) begin
              p2[al] = b;
              p2[br] = a;
            end
          end
          ok = is_interlaced(p1, p2, n);
        end
      end else begin
        pos = m - (n - 1);
        if (pos < 2*n - 1 && p2[pos] != p2[pos+1]) begin
          t = p2[pos];
          p2[pos] = p2[pos+1];
          p2[pos+1] = t;
          ok = is_interlaced(p1, p2, n);
        end
      end
      if (ok) begin
        prop = psi_stat(p1, p2, n);
        delta = prop - psi_now;
        one = 64'd1 << FB;
        base = delta >= 0 ? 64'(q_reg) : 64'(qinv_reg);
        reps = delta >= 0 ? delta : -delta;
        pw = one;
        for (int j = 0; j < reps; j++) begin
          pw = (pw * base) >> FB;
          if (pw > one) pw = one;
          if (pw == 0) break;
        end
        if (({40'd0, u} << FB) < (pw << UNIFORM_BITS)) begin
          acc = 1;
          row1 = p1;
          row2 = p2;
          psi_now = prop;
        end
      end
    end
    r.valid_move = ok;
    r.accepted = acc;
    r.psi = psi_now > 511 ? 9'd511 : 9'(psi_now);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    step_result_t e;
    if (rst_n && out_strobe) begin
      idle_cycles <= 0;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_valid_move !== e.valid_move) begin
          $error("valid_move exp %0d got %0d", e.valid_move, out_valid_move);
          errors++;
        end
        if (out_accepted !== e.accepted) begin
          $error("accepted exp %0d got %0d", e.accepted, out_accepted);
          errors++;
        end
        if (out_psi_value !== e.psi) begin
          $error("psi_value exp %0d got %0d", e.psi, out_psi_value);
          errors++;
        end
      end
    end else if (start && !busy) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_step(bit rs, int m, logic [23:0] u);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_restart <= rs;
    in_move_index <= MOVE_W'(m);
    in_uniform_fraction <= u;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.insert(expected_q.size(), predict_step(rs, m, u));
  endtask

  task automatic wait_drained();
    start <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_drained();
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= CFG_AW'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_N_COLORS: begin ncol_reg = val[4:0]; reload_identity(); end
      REG_WEIGHT_Q: q_reg = val;
      REG_WEIGHT_Q_INV: qinv_reg = val;
      default: ;
    endcase
  endtask

  function automatic logic [23:0] rand_u();
    case ($urandom_range(3))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_step(0, 0, 24'd0);
    send_step(0, 3, 24'd0);
    send_step(0, 4, 24'd0);
    send_step(0, 10, 24'd0);
    send_step(0, 11, 24'd0);
    send_step(0, 63, 24'hFFFFFF);
    send_step(0, 1, 24'hFFFFFF);
    send_step(1, 5, 24'h123456);
    send_step(0, 2, 24'h800000);
    send_step(0, 5, 24'd1);
    send_step(0, 6, 24'hFFFFFE);
    send_step(1, 63, 24'hFFFFFF);
  endtask

  task automatic test_random(int count, int span);
    int m;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 2) m = $urandom_range(63);
      else m = $urandom_range(span);
      send_step($urandom_range(49) == 0, m, rand_u());
    end
  endtask

  task automatic test_configs();
    write_reg(REG_WEIGHT_Q, 32'h0080_0000);
    write_reg(REG_WEIGHT_Q_INV, 32'h0200_0000);
    test_random(200, 12);
    write_reg(REG_N_COLORS, 32'd1);
    test_random(40, 4);
    write_reg(REG_N_COLORS, 32'd0);
    write_reg(REG_WEIGHT_Q, 32'hFFFF_FFFF);
    write_reg(REG_WEIGHT_Q_INV, 32'd1);
    test_random(40, 4);
    write_reg(REG_N_COLORS, 32'd16);
    test_random(100, 46);
    write_reg(REG_N_COLORS, 32'd31);
    write_reg(REG_WEIGHT_Q, 32'h0140_0000);
    write_reg(REG_WEIGHT_Q_INV, 32'h00CC_CCCD);
    test_random(120, 46);
    write_reg(REG_N_COLORS, 32'd6);
    write_reg(REG_WEIGHT_Q, 32'h0000_0001);
    write_reg(REG_WEIGHT_Q_INV, 32'h0100_0000);
    test_random(150, 16);
  endtask

  task automatic test_idle_phases();
    write_reg(REG_N_COLORS, 32'd5);
    write_reg(REG_WEIGHT_Q, 32'h00C0_0000);
    write_reg(REG_WEIGHT_Q_INV, 32'h0155_5555);
    send_idle_pct = 19;
    test_random(330, 14);
    send_idle_pct = 47;
    test_random(330, 14);
    wait_drained();
    send_idle_pct = 0;
    write_reg(REG_N_COLORS, 32'd8);
    test_random(330, 22);
  endtask

  initial begin
    ncol_reg = N_COLORS_RESET;
    q_reg = WEIGHT_RESET;
    qinv_reg = WEIGHT_RESET;
    reload_identity();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_configs();
    test_idle_phases();
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

/* interlacing_triangle_metropolis_step_core.f */
rtl/core/itms_pkg.sv
rtl/core/interlacing_triangle_metropolis_step_core.sv
tb/sv/testbench.sv
